// File: design/mbe_pkg.sv
// shared types, constants and fixed-point helpers for the escape-time evaluator
// no dependencies
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int Z_W       = 32;
    localparam int LIMIT_W   = 8;
    localparam int COORD_W   = 11;
    localparam int STEP_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int MAP_W     = STEP_W + COORD_W;
    localparam int MAP_SUM_W = MAP_W + 2;
    localparam int ACC_W     = Z_W + 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 3'd4;

    localparam logic [LIMIT_W-1:0]    RST_LIMIT       = 8'd100;
    localparam logic signed [Z_W-1:0] RST_REAL_ORIGIN = -32'sd939524096;
    localparam logic [STEP_W-1:0]     RST_REAL_STEP   = 31'd1468006;
    localparam logic signed [Z_W-1:0] RST_IMAG_ORIGIN = -32'sd536870912;
    localparam logic [STEP_W-1:0]     RST_IMAG_STEP   = 31'd1491308;

    // |z|^2 escape threshold, 4.0 in fixed point
    localparam logic [Z_W:0] ESC_BOUND = 33'd4 << FRAC_BITS;

    typedef struct packed {
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
    } cpoint_t;

    function automatic logic signed [Z_W-1:0] sat_map(input logic signed [MAP_SUM_W-1:0] v);
        logic [MAP_SUM_W-Z_W:0] hi;
        hi = v[MAP_SUM_W-1:Z_W-1];
        if ((&hi) || (~|hi))
            return v[Z_W-1:0];
        else
            return {v[MAP_SUM_W-1], {(Z_W-1){~v[MAP_SUM_W-1]}}};
    endfunction

    function automatic logic signed [Z_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-Z_W:0] hi;
        hi = v[ACC_W-1:Z_W-1];
        if ((&hi) || (~|hi))
            return v[Z_W-1:0];
        else
            return {v[ACC_W-1], {(Z_W-1){~v[ACC_W-1]}}};
    endfunction

    // floor shift of a full product back to the fixed-point scale, then saturate
    function automatic logic signed [Z_W-1:0] fx_scale(input logic signed [2*Z_W-1:0] p);
        logic [2*Z_W-FRAC_BITS-Z_W:0] hi;
        hi = p[2*Z_W-1:FRAC_BITS+Z_W-1];
        if ((&hi) || (~|hi))
            return p[FRAC_BITS+Z_W-1:FRAC_BITS];
        else
            return {p[2*Z_W-1], {(Z_W-1){~p[2*Z_W-1]}}};
    endfunction

endpackage

`default_nettype wire

// File: design/mbe_front.sv
// front end: accepts pixel items and maps them to complex points c
// depends on mbe_pkg
`default_nettype none

module mbe_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [mbe_pkg::COORD_W-1:0] pixel_col,
    input  wire logic [mbe_pkg::COORD_W-1:0] pixel_row,
    input  wire logic signed [mbe_pkg::Z_W-1:0] real_origin,
    input  wire logic [mbe_pkg::STEP_W-1:0]  real_step,
    input  wire logic signed [mbe_pkg::Z_W-1:0] imag_origin,
    input  wire logic [mbe_pkg::STEP_W-1:0]  imag_step,
    input  wire logic                        queue_full,
    output logic                             push,
    output mbe_pkg::cpoint_t                 point
);
    import mbe_pkg::*;

    logic             valid_reg, valid_next;
    logic [MAP_W-1:0] re_prod_reg, im_prod_reg;
    logic             advance;

    assign advance  = !valid_reg || !queue_full;
    assign in_stall = !advance;
    assign push     = valid_reg && !queue_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // step times index is exact, registered before the add
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            re_prod_reg <= real_step * pixel_col;
            im_prod_reg <= imag_step * pixel_row;
        end
    end

    always_comb
    begin
        point.re = sat_map(MAP_SUM_W'(real_origin) + $signed({2'b00, re_prod_reg}));
        point.im = sat_map(MAP_SUM_W'(imag_origin) + $signed({2'b00, im_prod_reg}));
    end

endmodule

`default_nettype wire

// File: design/mbe_queue.sv
// four-entry queue of mapped points between front end and iteration core
// depends on mbe_pkg
`default_nettype none

module mbe_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mbe_pkg::cpoint_t wdata,
    input  wire logic             pop,
    output mbe_pkg::cpoint_t      rdata,
    output logic                  full,
    output logic                  empty
);
    import mbe_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    cpoint_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// File: design/mbe_core.sv
// back end: z = z^2 + c iteration, brightness divide and output register
// depends on mbe_pkg
`default_nettype none

module mbe_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        queue_empty,
    input  wire mbe_pkg::cpoint_t            head,
    output logic                             pop,
    input  wire logic [mbe_pkg::LIMIT_W-1:0] iteration_limit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [mbe_pkg::LIMIT_W-1:0]      iter_count,
    output logic                             inside_set,
    output logic [mbe_pkg::LIMIT_W-1:0]      brightness
);
    import mbe_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic signed [Z_W-1:0]     cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [Z_W-1:0]     zr_next, zi_next;
    logic signed [2*Z_W-1:0]   pxx_reg, pyy_reg, pxy_reg;
    logic [LIMIT_W-1:0]        upd_reg, upd_next;
    logic [LIMIT_W-1:0]        n_reg, n_next;
    logic                      inside_reg, inside_next;
    logic [LIMIT_W-1:0]        rem_reg, rem_next;
    logic [LIMIT_W-1:0]        dlow_reg, dlow_next;
    logic [LIMIT_W-1:0]        quo_reg, quo_next;
    logic [2:0]                dcnt_reg, dcnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [LIMIT_W-1:0]        cnt_out_reg, bright_out_reg;
    logic                      inside_out_reg;
    logic                      load_z, load_prod, load_out;

    logic signed [Z_W-1:0]     xx, yy, xy;
    logic [Z_W:0]              mag;
    logic                      escaped;
    logic [2*LIMIT_W-1:0]      dividend;
    logic [LIMIT_W-1:0]        esc_n;
    logic [LIMIT_W:0]          trial, diff;
    logic                      ge;

    // squared terms of the current z, scaled back and saturated
    assign xx  = fx_scale(pxx_reg);
    assign yy  = fx_scale(pyy_reg);
    assign xy  = fx_scale(pxy_reg);
    assign mag = {1'b0, xx} + {1'b0, yy};
    // the starting point c itself is never tested
    assign escaped = (upd_reg != '0) && (mag > ESC_BOUND);

    assign esc_n    = upd_reg - LIMIT_W'(1);
    assign dividend = {esc_n, {LIMIT_W{1'b0}}} - {{LIMIT_W{1'b0}}, esc_n};

    assign trial = {rem_reg, dlow_reg[LIMIT_W-1]};
    assign ge    = (trial >= {1'b0, iteration_limit});
    assign diff  = trial - {1'b0, iteration_limit};

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign pop      = (state_reg == ST_IDLE) && !queue_empty;

    always_comb
    begin
        state_next  = state_reg;
        upd_next    = upd_reg;
        n_next      = n_reg;
        inside_next = inside_reg;
        rem_next    = rem_reg;
        dlow_next   = dlow_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;
        zr_next     = sat_acc(ACC_W'(xx) - ACC_W'(yy) + ACC_W'(cr_reg));
        zi_next     = sat_acc((ACC_W'(xy) <<< 1) + ACC_W'(ci_reg));
        load_z      = 1'b0;
        load_prod   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    upd_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                load_prod  = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (escaped)
                begin
                    n_next      = esc_n;
                    inside_next = 1'b0;
                    rem_next    = dividend[2*LIMIT_W-1:LIMIT_W];
                    dlow_next   = dividend[LIMIT_W-1:0];
                    quo_next    = '0;
                    dcnt_next   = '0;
                    state_next  = ST_DIV;
                end
                else if (upd_reg == iteration_limit)
                begin
                    n_next      = upd_reg;
                    inside_next = 1'b1;
                    quo_next    = '0;
                    state_next  = ST_OUT;
                end
                else
                begin
                    load_z     = 1'b1;
                    upd_next   = upd_reg + LIMIT_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rem_next  = ge ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
                quo_next  = {quo_reg[LIMIT_W-2:0], ge};
                dlow_next = {dlow_reg[LIMIT_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + 3'd1;
                if (dcnt_reg == 3'd7)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_reg    <= upd_next;
        n_reg      <= n_next;
        inside_reg <= inside_next;
        rem_reg    <= rem_next;
        dlow_reg   <= dlow_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        if (pop)
        begin
            cr_reg <= head.re;
            ci_reg <= head.im;
            zr_reg <= head.re;
            zi_reg <= head.im;
        end
        else if (load_z)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
        if (load_prod)
        begin
            pxx_reg <= zr_reg * zr_reg;
            pyy_reg <= zi_reg * zi_reg;
            pxy_reg <= zr_reg * zi_reg;
        end
        if (load_out)
        begin
            cnt_out_reg    <= n_reg;
            inside_out_reg <= inside_reg;
            bright_out_reg <= inside_reg ? '0 : quo_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign iter_count = cnt_out_reg;
    assign inside_set = inside_out_reg;
    assign brightness = bright_out_reg;

endmodule

`default_nettype wire

// File: design/mandelbrot_escape_time.sv
// top level of the escape-time evaluator: configuration registers and wiring
// depends on mbe_pkg, mbe_front, mbe_queue, mbe_core
//
// usage: pixel items (pixel_col, pixel_row) enter on in_valid/in_stall; each
// gives one result (iter_count, inside_set, brightness) on out_valid/out_stall.
// registers are written through cfg_valid/cfg_ready (always ready) with
// cfg_index 0..4 = iteration limit, real origin, real step, imag origin,
// imag step; other indexes are ignored. write them only while the block is idle.
// the front end takes one item per cycle into a four-entry queue of mapped
// points, so input stalls only when that queue is full.
// the iteration core handles one point at a time on one complex squaring unit:
// each z update is a multiply state followed by a scale/add/test state, and
// escaping points also pass through the brightness division before their
// result is registered.
// reset clears all handshake state and loads the default registers
// (limit 100, window -3.5..3.5 by -2..2 over 1280 x 720 pixels).
// a stalled result is held in the output register; the core then waits with
// its next result, and the queue keeps taking items until it fills.
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbe_pkg::Z_W-1:0]       cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mbe_pkg::COORD_W-1:0]   pixel_col,
    input  wire logic [mbe_pkg::COORD_W-1:0]   pixel_row,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mbe_pkg::LIMIT_W-1:0]        iter_count,
    output logic                               inside_set,
    output logic [mbe_pkg::LIMIT_W-1:0]        brightness
);
    import mbe_pkg::*;

    logic [LIMIT_W-1:0]    limit_reg;
    logic signed [Z_W-1:0] real_origin_reg, imag_origin_reg;
    logic [STEP_W-1:0]     real_step_reg, imag_step_reg;
    logic                  cfg_write;

    logic    push, pop, queue_full, queue_empty;
    cpoint_t front_point, head_point;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= RST_LIMIT;
            real_origin_reg <= RST_REAL_ORIGIN;
            real_step_reg   <= RST_REAL_STEP;
            imag_origin_reg <= RST_IMAG_ORIGIN;
            imag_step_reg   <= RST_IMAG_STEP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LIMIT:       limit_reg       <= cfg_data[LIMIT_W-1:0];
                CFG_REAL_ORIGIN: real_origin_reg <= cfg_data;
                CFG_REAL_STEP:   real_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_IMAG_ORIGIN: imag_origin_reg <= cfg_data;
                CFG_IMAG_STEP:   imag_step_reg   <= cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    mbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .real_origin (real_origin_reg),
        .real_step   (real_step_reg),
        .imag_origin (imag_origin_reg),
        .imag_step   (imag_step_reg),
        .queue_full  (queue_full),
        .push        (push),
        .point       (front_point)
    );

    mbe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_point),
        .pop   (pop),
        .rdata (head_point),
        .full  (queue_full),
        .empty (queue_empty)
    );

    mbe_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .head            (head_point),
        .pop             (pop),
        .iteration_limit (limit_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iter_count      (iter_count),
        .inside_set      (inside_set),
        .brightness      (brightness)
    );

endmodule

`default_nettype wire
